// ===== src/bpr_pkg.sv =====
// ---------------------------------------------------------------------------
// bpr_pkg: shared types and constants of the byte pipe ring buffer
// Depth, field widths, operation codes and the structs passed between the
// controller, the byte memory and the output queue.
// ---------------------------------------------------------------------------
package bpr_pkg;

    // ring depth in bytes, 2 .. 64
    localparam int DEPTH       = 64;
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // field widths of the stream beats
    localparam int LEN_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - 2 * CNT_W;

    // output queue between the result stage and the master side
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // operation codes carried in s_axis_tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // one result beat
    typedef struct packed {
        byte_t data_byte_out;
        logic  byte_valid;
        cnt_t  count;
        cnt_t  fill_level;
        logic  last;
    } result_t;

    // memory port request from the controller
    typedef struct packed {
        logic  wr_en;
        ptr_t  wr_addr;
        byte_t wr_data;
        logic  rd_en;
        ptr_t  rd_addr;
    } ram_req_t;

    // result push into the output queue
    typedef struct packed {
        logic    valid;
        result_t res;
    } out_push_t;

    // next ring position with wrap at the depth
    function automatic ptr_t ptr_advance(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== src/bpr_ram.sv =====
// ---------------------------------------------------------------------------
// bpr_ram: byte storage of the ring
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module bpr_ram
    import bpr_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output byte_t    rd_q
);

    byte_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_q <= mem[req.rd_addr];
        end
    end

endmodule

// ===== src/bpr_out_fifo.sv =====
// ---------------------------------------------------------------------------
// bpr_out_fifo: result queue in front of the master side
// Small register queue that decouples the result stage from downstream stalls.
// ---------------------------------------------------------------------------
module bpr_out_fifo
    import bpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  out_push_t            push,
    input  logic                 pop,
    output logic                 head_valid,
    output result_t              head,
    output logic [OUT_CNT_W-1:0] fill_cnt
);

    result_t              slot [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] head_reg, head_next;
    logic [OUT_PTR_W-1:0] tail_reg, tail_next;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 do_pop;

    assign do_pop     = pop && (cnt_reg != '0);
    assign head_valid = (cnt_reg != '0);
    assign head       = slot[head_reg];
    assign fill_cnt   = cnt_reg;

    // pointer and occupancy update
    always_comb
    begin
        head_next = do_pop ? head_reg + 1'b1 : head_reg;
        tail_next = push.valid ? tail_reg + 1'b1 : tail_reg;
        cnt_next  = cnt_reg + OUT_CNT_W'(push.valid) - OUT_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot[tail_reg] <= push.res;
        end
    end

    // the controller's credit check keeps the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !do_pop) |-> (cnt_reg < OUT_CNT_W'(OUT_DEPTH)))
        else $error("bpr_out_fifo: push into a full queue");

endmodule

// ===== src/bpr_ctrl.sv =====
// ---------------------------------------------------------------------------
// bpr_ctrl: ring pointers, write run bookkeeping and read sequencer
// Accepts input beats, drives the byte memory and forms result beats in the
// next cycle, when the memory read data is available.
// ---------------------------------------------------------------------------
module bpr_ctrl
    import bpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 mode,
    input  logic [LEN_W-1:0]     length,
    input  byte_t                data_byte,
    input  logic                 last_of_write,
    output ram_req_t             ram_req,
    input  byte_t                ram_q,
    output out_push_t            push,
    input  logic [OUT_CNT_W-1:0] fifo_cnt
);

    typedef enum logic {ST_IDLE, ST_READ} state_t;

    state_t state_reg, state_next;
    ptr_t   rd_ptr_reg, rd_ptr_next;
    ptr_t   wr_ptr_reg, wr_ptr_next;
    cnt_t   stored_reg, stored_next;
    logic   run_active_reg, run_active_next;
    logic   run_acc_reg, run_acc_next;
    cnt_t   run_written_reg, run_written_next;
    cnt_t   run_target_reg, run_target_next;
    cnt_t   remain_reg, remain_next;
    cnt_t   total_reg, total_next;
    cnt_t   fill_after_reg, fill_after_next;

    // result stage: holds the beat while the memory read data is registered
    logic   pend_valid_reg, pend_valid_next;
    logic   pend_bv_reg, pend_bv_next;
    cnt_t   pend_cnt_reg, pend_cnt_next;
    cnt_t   pend_fill_reg, pend_fill_next;
    logic   pend_last_reg, pend_last_next;

    logic   credit_ok;
    logic   accept;
    logic   first;
    cnt_t   clamp;
    logic   acc;
    cnt_t   tgt;
    cnt_t   wr_cnt;
    logic   do_write;
    cnt_t   n_rd;

    // room for the beat in flight plus one more issue
    assign credit_ok = ((OUT_CNT_W + 1)'(fifo_cnt) + (OUT_CNT_W + 1)'(pend_valid_reg))
                       < (OUT_CNT_W + 1)'(OUT_DEPTH);
    assign s_ready   = (state_reg == ST_IDLE) && credit_ok;
    assign accept    = s_valid && s_ready;

    // write run decode
    always_comb
    begin
        first  = !run_active_reg;
        clamp  = (length > LEN_W'(DEPTH)) ? DEPTH_CNT : length[CNT_W-1:0];
        acc    = first ? ((clamp != '0) && ((DEPTH_CNT - stored_reg) >= clamp))
                       : run_acc_reg;
        tgt    = first ? clamp : run_target_reg;
        wr_cnt = first ? '0 : run_written_reg;
        do_write = acc && (wr_cnt < tgt) && (stored_reg < DEPTH_CNT);
        n_rd   = (length < LEN_W'(stored_reg)) ? length[CNT_W-1:0] : stored_reg;
    end

    // next state
    always_comb
    begin
        state_next       = state_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        stored_next      = stored_reg;
        run_active_next  = run_active_reg;
        run_acc_next     = run_acc_reg;
        run_written_next = run_written_reg;
        run_target_next  = run_target_reg;
        remain_next      = remain_reg;
        total_next       = total_reg;
        fill_after_next  = fill_after_reg;
        pend_valid_next  = 1'b0;
        pend_bv_next     = pend_bv_reg;
        pend_cnt_next    = pend_cnt_reg;
        pend_fill_next   = pend_fill_reg;
        pend_last_next   = pend_last_reg;
        ram_req          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_WRITE))
                begin
                    // byte of a write run, stored as it arrives
                    if (do_write)
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = wr_ptr_reg;
                        ram_req.wr_data = data_byte;
                        wr_ptr_next     = ptr_advance(wr_ptr_reg);
                        stored_next     = stored_reg + 1'b1;
                    end
                    if (last_of_write)
                    begin
                        pend_valid_next  = 1'b1;
                        pend_bv_next     = 1'b0;
                        pend_cnt_next    = wr_cnt + cnt_t'(do_write);
                        pend_fill_next   = stored_reg + cnt_t'(do_write);
                        pend_last_next   = 1'b1;
                        run_active_next  = 1'b0;
                        run_acc_next     = 1'b0;
                        run_written_next = '0;
                        run_target_next  = '0;
                    end
                    else
                    begin
                        run_active_next  = 1'b1;
                        run_acc_next     = acc;
                        run_written_next = wr_cnt + cnt_t'(do_write);
                        run_target_next  = tgt;
                    end
                end
                else if (accept)
                begin
                    if (n_rd == '0)
                    begin
                        // nothing to return: single empty result
                        pend_valid_next = 1'b1;
                        pend_bv_next    = 1'b0;
                        pend_cnt_next   = '0;
                        pend_fill_next  = stored_reg;
                        pend_last_next  = 1'b1;
                    end
                    else
                    begin
                        // first byte of the read goes out right away
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = rd_ptr_reg;
                        rd_ptr_next     = ptr_advance(rd_ptr_reg);
                        stored_next     = stored_reg - n_rd;
                        total_next      = n_rd;
                        fill_after_next = stored_reg - n_rd;
                        remain_next     = n_rd - 1'b1;
                        pend_valid_next = 1'b1;
                        pend_bv_next    = 1'b1;
                        pend_cnt_next   = n_rd;
                        pend_fill_next  = stored_reg - n_rd;
                        pend_last_next  = (n_rd == cnt_t'(1));
                        if (n_rd != cnt_t'(1))
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                // one byte per cycle while the output queue has room
                if (credit_ok)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_ptr_reg;
                    rd_ptr_next     = ptr_advance(rd_ptr_reg);
                    remain_next     = remain_reg - 1'b1;
                    pend_valid_next = 1'b1;
                    pend_bv_next    = 1'b1;
                    pend_cnt_next   = total_reg;
                    pend_fill_next  = fill_after_reg;
                    pend_last_next  = (remain_reg == cnt_t'(1));
                    if (remain_reg == cnt_t'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            stored_reg      <= '0;
            run_active_reg  <= 1'b0;
            run_acc_reg     <= 1'b0;
            run_written_reg <= '0;
            run_target_reg  <= '0;
            remain_reg      <= '0;
            total_reg       <= '0;
            fill_after_reg  <= '0;
            pend_valid_reg  <= 1'b0;
            pend_bv_reg     <= 1'b0;
            pend_cnt_reg    <= '0;
            pend_fill_reg   <= '0;
            pend_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            stored_reg      <= stored_next;
            run_active_reg  <= run_active_next;
            run_acc_reg     <= run_acc_next;
            run_written_reg <= run_written_next;
            run_target_reg  <= run_target_next;
            remain_reg      <= remain_next;
            total_reg       <= total_next;
            fill_after_reg  <= fill_after_next;
            pend_valid_reg  <= pend_valid_next;
            pend_bv_reg     <= pend_bv_next;
            pend_cnt_reg    <= pend_cnt_next;
            pend_fill_reg   <= pend_fill_next;
            pend_last_reg   <= pend_last_next;
        end
    end

    // result beat, read byte taken from the memory output
    always_comb
    begin
        push.valid             = pend_valid_reg;
        push.res.data_byte_out = pend_bv_reg ? ram_q : '0;
        push.res.byte_valid    = pend_bv_reg;
        push.res.count         = pend_cnt_reg;
        push.res.fill_level    = pend_fill_reg;
        push.res.last          = pend_last_reg;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= DEPTH_CNT)
        else $error("bpr_ctrl: fill level above depth");

    a_read_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (remain_reg != '0))
        else $error("bpr_ctrl: read sequencer active with nothing left");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_written_reg <= run_target_reg)
        else $error("bpr_ctrl: write run wrote past its reservation");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        ((OUT_CNT_W + 1)'(fifo_cnt) + (OUT_CNT_W + 1)'(pend_valid_reg))
            <= (OUT_CNT_W + 1)'(OUT_DEPTH))
        else $error("bpr_ctrl: results in flight exceed queue room");

endmodule

// ===== src/byte_pipe_ring_buffer.sv =====
// ---------------------------------------------------------------------------
// byte_pipe_ring_buffer: non-blocking byte pipe with atomic writes
// Circular byte store; write runs are reserved whole or dropped, reads
// return up to the requested count as a marked run of beats.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation beat: tuser = mode (write byte / read
//   request), tlast = end of a write run, tdata = length and data byte.
//   A write run's first beat reserves min(length, depth) bytes; if that
//   does not fit, the whole run is dropped. The tlast beat of a run gives
//   one result with the count written. A read gives min(length, fill)
//   beats with tuser set, or one empty beat.
//   m_axis carries results: tdata = byte, count, fill level; tlast marks
//   the final beat of an operation.
// Flow: write bytes one per cycle while the result queue has room; a read
//   holds the input until its last byte is issued (one memory read per
//   cycle, one read port); results pass the result stage and the queue.
// Reset clears pointers, fill level and run state; the store needs no
//   clearing. When m_axis stalls, a four-beat result queue fills and
//   s_axis_tready drops until room returns.
// ---------------------------------------------------------------------------
module byte_pipe_ring_buffer
    import bpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] length, [23:16] data_byte
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] data_byte_out, [14:8] count, [21:15] fill_level, [23:22] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] byte_valid
    output logic                   m_axis_tuser,
    output logic                   m_axis_tlast
);

    ram_req_t             ram_req;
    byte_t                ram_q;
    out_push_t            push;
    result_t              head;
    logic [OUT_CNT_W-1:0] fifo_cnt;

    // controller and sequencer
    bpr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_valid       (s_axis_tvalid),
        .s_ready       (s_axis_tready),
        .mode          (s_axis_tuser),
        .length        (s_axis_tdata[LEN_W-1:0]),
        .data_byte     (s_axis_tdata[LEN_W +: BYTE_W]),
        .last_of_write (s_axis_tlast),
        .ram_req       (ram_req),
        .ram_q         (ram_q),
        .push          (push),
        .fifo_cnt      (fifo_cnt)
    );

    // byte store
    bpr_ram u_ram (
        .clk  (clk),
        .req  (ram_req),
        .rd_q (ram_q)
    );

    // result queue
    bpr_out_fifo u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_axis_tready),
        .head_valid (m_axis_tvalid),
        .head       (head),
        .fill_cnt   (fifo_cnt)
    );

    // pack the result beat
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, head.fill_level, head.count,
                           head.data_byte_out};
    assign m_axis_tuser = head.byte_valid;
    assign m_axis_tlast = head.last;

endmodule
